[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Holds the item kinds, the blank cell value, stream widths and the command
// and status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Default screen geometry.
	localparam int DEFAULT_COLUMNS = 80;
	localparam int DEFAULT_ROWS    = 25;

	// Stream payload widths.
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	// Item kinds carried on the input tuser.
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// Character codes and the blank cell (attribute high, character low).
	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [7:0]  BLANK_CHAR   = 8'h20;
	localparam logic [7:0]  BLANK_ATTR   = 8'h07;
	localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item; // capture the input transfer
		logic cnt_clr;   // restart the sweep counter
		logic step;      // carry out the captured item
		logic sweep;     // process one cell of a sweep
		logic copy;      // sweep copies rows upwards rather than blanking
		logic load_out;  // load the result into the output register
	} tcw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [KIND_W-1:0] kind;     // kind of the captured item
		logic              scroll;   // the captured write pushes past the last row
		logic              cnt_last; // sweep counter is on the last cell
		logic              out_free; // output register can take a result
	} tcw_sts_t;

endpackage

[src/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing state machine of the text console writer
// Runs the clearing pass after reset, takes one item at a time, starts the
// scroll and clear sweeps and hands each result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tcw_pkg::tcw_sts_t sts,
	output tcw_pkg::tcw_cmd_t cmd
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       in_xfer;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// Next state and command decode.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.cnt_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer) begin
					cmd.load_item = 1'b1;
					cmd.cnt_clr   = 1'b1;
					state_next    = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.step = 1'b1;
				case (sts.kind)
					tcw_pkg::KIND_WRITE: begin
						state_next = sts.scroll ? ST_SCROLL : ST_RESULT;
					end
					tcw_pkg::KIND_CLEAR: begin
						state_next = ST_CLEAR;
					end
					default: begin
						state_next = ST_RESULT;
					end
				endcase
			end
			ST_SCROLL: begin
				cmd.sweep = 1'b1;
				cmd.copy  = 1'b1;
				if (sts.cnt_last) begin
					state_next = ST_RESULT;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.cnt_last) begin
					state_next = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_next;
		end
	end

	// An accepted transfer is always decoded in the following cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_DECODE)
		else $error("accepted item not decoded next cycle");

	// A result is only loaded while the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a pending result");

endmodule

[src/tcw_dp.sv]
// ----------------------------------------------------------------------------
// tcw_dp: datapath of the text console writer
// Holds the cell store, the cursor, the sweep counter with its one-stage
// write pipeline, and the output register of the result stream.
// ----------------------------------------------------------------------------
module tcw_dp #(
	parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic [tcw_pkg::KIND_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  tcw_pkg::tcw_cmd_t                  cmd,
	output tcw_pkg::tcw_sts_t                  sts
);

	localparam int NCELL = ROWS * COLUMNS;
	localparam int AW    = $clog2(NCELL);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(NCELL - 1);

	// Captured item.
	logic [tcw_pkg::KIND_W-1:0] kind_q;
	logic [7:0]                 code_q;
	logic [7:0]                 color_q;
	logic [10:0]                index_q;

	// Cursor and sweep state.
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] cnt_q;
	logic          hit_q;

	// Write stage and memory.
	logic [15:0]   mem [NCELL];
	logic          wr_v_s1;
	logic          wr_copy_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [15:0]   wr_data_s1;
	logic [15:0]   wdata;
	logic [15:0]   rd_data_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// Output register.
	logic                            out_valid_q;
	logic [tcw_pkg::OUT_TDATA_W-1:0] out_data_q;

	// Derived values.
	logic [31:0]   cur_pos;
	logic [31:0]   src_sum;
	logic [31:0]   idx_ext;
	logic [31:0]   row_ext;
	logic [31:0]   col_ext;
	logic          src_ok;
	logic          idx_ok;
	logic          is_nl;
	logic          row_adv;
	logic          is_write;

	assign cur_pos  = 32'(row_q) * 32'(COLUMNS) + 32'(col_q);
	assign src_sum  = 32'(cnt_q) + 32'(COLUMNS);
	assign src_ok   = (32'(cnt_q) < 32'(NCELL - COLUMNS));
	assign idx_ext  = 32'(index_q);
	assign idx_ok   = (idx_ext < 32'(NCELL));
	assign row_ext  = 32'(row_q);
	assign col_ext  = 32'(col_q);
	assign is_nl    = (code_q == tcw_pkg::NEWLINE_CODE);
	assign row_adv  = is_nl || (col_q == COL_LAST);
	assign is_write = (kind_q == tcw_pkg::KIND_WRITE);

	// Status towards the controller.
	assign sts.kind     = kind_q;
	assign sts.scroll   = is_write && row_adv && (row_q == ROW_LAST);
	assign sts.cnt_last = (cnt_q == CELL_LAST);
	assign sts.out_free = !out_valid_q || m_tready;

	// Item capture on an input transfer.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= s_tuser;
			code_q  <= s_tdata[7:0];
			color_q <= s_tdata[15:8];
			index_q <= s_tdata[26:16];
		end
	end

	// Cursor update, read hit flag and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.sweep) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.step) begin
				hit_q <= (kind_q == tcw_pkg::KIND_READ) && idx_ok;
				case (kind_q)
					tcw_pkg::KIND_WRITE: begin
						if (row_adv) begin
							col_q <= '0;
							if (row_q != ROW_LAST) begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
					tcw_pkg::KIND_CLEAR: begin
						row_q <= '0;
						col_q <= '0;
					end
					default: begin
						row_q <= row_q;
					end
				endcase
			end
		end
	end

	// Write stage: one cell write is issued per cycle into the stage registers and lands in the store in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= cmd.sweep || (cmd.step && is_write && !is_nl);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			wr_addr_s1 <= cnt_q;
			wr_copy_s1 <= cmd.copy && src_ok;
			wr_data_s1 <= tcw_pkg::BLANK_CELL;
		end else begin
			wr_addr_s1 <= cur_pos[AW-1:0];
			wr_copy_s1 <= 1'b0;
			wr_data_s1 <= {color_q, code_q};
		end
	end

	// Read port: the row below during a scroll, or the requested cell.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_ext[AW-1:0];
		if (cmd.sweep && cmd.copy && src_ok) begin
			rd_en   = 1'b1;
			rd_addr = src_sum[AW-1:0];
		end else if (cmd.step && (kind_q == tcw_pkg::KIND_READ) && idx_ok) begin
			rd_en = 1'b1;
		end
	end

	assign wdata = wr_copy_s1 ? rd_data_q : wr_data_s1;

	// Cell store.
	always_ff @(posedge clk) begin
		if (wr_v_s1) begin
			mem[wr_addr_s1] <= wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Output register of the result stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {1'b0,
				hit_q ? rd_data_q[15:8] : 8'h00,
				hit_q ? rd_data_q[7:0] : 8'h00,
				cur_pos[10:0], col_ext[6:0], row_ext[4:0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The cursor never leaves the screen.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_ext < 32'(ROWS))
		else $error("cursor row beyond the screen");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < 32'(COLUMNS))
		else $error("cursor column beyond the screen");

	// Every write lands inside the store.
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> 32'(wr_addr_s1) < 32'(NCELL))
		else $error("cell write outside the store");

endmodule

[src/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console over a ROWS x COLUMNS cell store
//
// Input stream (s_*): one transfer is one item. s_tuser gives the kind
// (write character, clear screen, read cell); s_tdata carries the character,
// colour and cell index. Output stream (m_*): exactly one transfer per item,
// giving the cursor row, column and linear position and, for a read, the
// character and attribute of the cell.
// One item is handled at a time. A plain character, newline, read or unused
// kind passes through capture, decode and result before the next ready. A
// write that moves past the last row adds a scroll sweep over every cell,
// which moves one cell per cycle through the single write port of the cell
// store; a clear screen likewise adds a sweep over every cell.
// The result appears on m_tvalid in the cycle after the result step.
// After reset the store is blanked in a clearing pass over every cell,
// during which s_tready stays low; the cursor starts at the home
// position. When the receiver stalls, the result is held in the output
// register and the next item can still be accepted and worked on; it then
// waits for the output register before finishing.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// char_code[7:0], color[15:8], cell_index[26:16], zero fill above
	input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [tcw_pkg::KIND_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cursor_row[4:0], cursor_column[11:5], cursor_position[22:12],
	// cell_char[30:23], cell_attr[38:31], zero fill above
	output logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata
);

	tcw_pkg::tcw_cmd_t cmd;
	tcw_pkg::tcw_sts_t sts;

	// Sequencing.
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Cell store, cursor and output register.
	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[tb/text_console_writer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Directed rows cover reset contents, out-of-range reads, the unused kind,
// null and extreme bytes, newline and clear. Random sequences of text runs,
// newline bursts, reads around the cursor and occasional clears then drive
// the cursor through wrapping and scrolling. Each result is compared with a
// given expected value or a shadow model of the cell store and cursor.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

	localparam int COLS         = tcw_pkg::DEFAULT_COLUMNS;
	localparam int ROWS         = tcw_pkg::DEFAULT_ROWS;
	localparam int CELLS        = COLS * ROWS;
	localparam int RANDOM_ITEMS = 1900;
	// A scroll or clear costs one cycle per cell, and so does the clearing pass
	// after reset; the limit sits well above that plus the longest stalls.
	localparam int IDLE_LIMIT   = 20000;

	// The kind that the block leaves alone.
	localparam logic [tcw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [tcw_pkg::KIND_W-1:0] kind;
		logic [10:0]                index;
		logic [7:0]                 color;
		logic [7:0]                 code;
	} cons_item_t;

	// Same layout as m_tdata, cursor row in the lowest bits.
	typedef struct packed {
		logic [7:0]  cell_attr;
		logic [7:0]  cell_char;
		logic [10:0] position;
		logic [6:0]  column;
		logic [4:0]  row;
	} cursor_rpt_t;

	typedef struct {
		cons_item_t  item;
		bit          fixed;
		cursor_rpt_t want;
	} directed_row_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [tcw_pkg::KIND_W-1:0]      s_tuser  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata;

	// Shadow copy of the cell store and cursor.
	logic [15:0] shadow_cells [CELLS];
	int unsigned cur_row;
	int unsigned cur_col;

	cursor_rpt_t   pending_reports [$];
	directed_row_t directed_rows [$];
	int            mismatches  = 0;
	int            idle_cycles = 0;
	int            burst_left  = 0;
	int            rx_mode     = 0;
	int            rx_left     = 0;

	text_console_writer #(
		.COLUMNS (COLS),
		.ROWS    (ROWS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = tcw_pkg::BLANK_CELL;
		cur_row = 0;
		cur_col = 0;
	endfunction

	// Applies one item to the shadow state and returns the report it causes.
	function automatic cursor_rpt_t console_step(input cons_item_t it);
		cursor_rpt_t rpt;
		int unsigned pos;
		rpt = '0;
		case (it.kind)
			tcw_pkg::KIND_WRITE: begin
				if (it.code == tcw_pkg::NEWLINE_CODE) begin
					cur_row++;
					cur_col = 0;
				end else begin
					pos = cur_row * COLS + cur_col;
					if (pos < CELLS)
						shadow_cells[pos] = {it.color, it.code};
					cur_col++;
				end
				if (cur_col >= COLS) begin
					cur_row++;
					cur_col = 0;
				end
				// Past the last row: every row moves up and the bottom row is blanked.
				if (cur_row >= ROWS) begin
					for (int i = 0; i < CELLS - COLS; i++)
						shadow_cells[i] = shadow_cells[i + COLS];
					for (int i = CELLS - COLS; i < CELLS; i++)
						shadow_cells[i] = tcw_pkg::BLANK_CELL;
					cur_row = ROWS - 1;
					cur_col = 0;
				end
			end
			tcw_pkg::KIND_CLEAR: blank_screen();
			tcw_pkg::KIND_READ: begin
				if (it.index < CELLS) begin
					rpt.cell_char = shadow_cells[it.index][7:0];
					rpt.cell_attr = shadow_cells[it.index][15:8];
				end
			end
			default: ;
		endcase
		pos          = cur_row * COLS + cur_col;
		rpt.row      = 5'(cur_row);
		rpt.column   = 7'(cur_col);
		rpt.position = 11'(pos);
		return rpt;
	endfunction

	function automatic cons_item_t random_item(input logic [tcw_pkg::KIND_W-1:0] kind);
		cons_item_t it;
		it.kind  = kind;
		it.code  = 8'($urandom_range(0, 255));
		it.color = 8'($urandom_range(0, 255));
		it.index = 11'($urandom_range(0, 2047));
		return it;
	endfunction

	task automatic add_row(input logic [tcw_pkg::KIND_W-1:0] kind, input int code,
			input int color, input int index, input bit fixed, input int row = 0,
			input int column = 0, input int position = 0, input int ch = 0,
			input int attr = 0);
		directed_row_t r;
		r.item           = '{kind: kind, index: 11'(index), color: 8'(color), code: 8'(code)};
		r.fixed          = fixed;
		r.want           = '0;
		r.want.row       = 5'(row);
		r.want.column    = 7'(column);
		r.want.position  = 11'(position);
		r.want.cell_char = 8'(ch);
		r.want.cell_attr = 8'(attr);
		directed_rows.push_back(r);
	endtask

	// Offers one item in bursts with random gaps, and records the expected
	// report once the transfer has been accepted.
	task automatic send_item(input cons_item_t it, input bit fixed = 1'b0,
			input cursor_rpt_t want = '0);
		cursor_rpt_t predicted;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {5'd0, it.index, it.color, it.code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = console_step(it);
		pending_reports.push_back(fixed ? want : predicted);
		burst_left--;
	endtask

	// Holds the sender off until every outstanding report has come back.
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (pending_reports.size() != 0);
	endtask

	// Receiver: phases of steady, light, heavy and near-total back-pressure.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 400);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 1) != 0);
			default: m_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Result checking and the watchdog.
	always @(posedge clk) begin
		cursor_rpt_t got;
		cursor_rpt_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(cursor_rpt_t)-1:0];
			if (pending_reports.size() == 0) begin
				$error("unexpected result transfer: %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (got.row !== want.row) begin
					$error("cursor_row: expected %0d, got %0d", want.row, got.row);
					mismatches++;
				end
				if (got.column !== want.column) begin
					$error("cursor_column: expected %0d, got %0d", want.column, got.column);
					mismatches++;
				end
				if (got.position !== want.position) begin
					$error("cursor_position: expected %0d, got %0d", want.position,
						got.position);
					mismatches++;
				end
				if (got.cell_char !== want.cell_char) begin
					$error("cell_char: expected %h, got %h", want.cell_char, got.cell_char);
					mismatches++;
				end
				if (got.cell_attr !== want.cell_attr) begin
					$error("cell_attr: expected %h, got %h", want.cell_attr, got.cell_attr);
					mismatches++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		cons_item_t  it;
		int unsigned sent;
		int unsigned seg;
		int unsigned n;
		int unsigned pick;
		int unsigned pos;
		int unsigned back;
		bit          paused;
		sent   = 0;
		paused = 1'b0;
		blank_screen();

		// Directed rows; expected values given where they are plain to see.
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, 0, 1, 0, 0, 0,
			tcw_pkg::BLANK_CHAR, tcw_pkg::BLANK_ATTR);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, CELLS - 1, 1, 0, 0, 0,
			tcw_pkg::BLANK_CHAR, tcw_pkg::BLANK_ATTR);
		add_row(tcw_pkg::KIND_READ, 8'hFF, 8'hFF, 2047, 1, 0, 0, 0, 0, 0);
		add_row(KIND_UNUSED, 8'hFF, 8'hFF, 2047, 1, 0, 0, 0, 0, 0);
		add_row(tcw_pkg::KIND_WRITE, 8'h00, 8'hFF, 0, 1, 0, 1, 1, 0, 0);
		add_row(tcw_pkg::KIND_WRITE, 8'hFF, 8'h00, 2047, 1, 0, 2, 2, 0, 0);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, 0, 1, 0, 2, 2, 8'h00, 8'hFF);
		add_row(tcw_pkg::KIND_READ, 8'hFF, 8'hFF, 1, 1, 0, 2, 2, 8'hFF, 8'h00);
		add_row(tcw_pkg::KIND_WRITE, tcw_pkg::NEWLINE_CODE, 8'h5A, 1024, 1, 1, 0, COLS,
			0, 0);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, CELLS, 1, 1, 0, COLS, 0, 0);
		add_row(tcw_pkg::KIND_WRITE, 8'h41, 8'h1E, 0, 0);
		add_row(tcw_pkg::KIND_WRITE, 8'h0B, 8'h70, 0, 0);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, COLS, 0);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, COLS + 1, 0);
		add_row(tcw_pkg::KIND_CLEAR, 8'hFF, 8'hFF, 2047, 1, 0, 0, 0, 0, 0);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, COLS, 1, 0, 0, 0,
			tcw_pkg::BLANK_CHAR, tcw_pkg::BLANK_ATTR);
		add_row(tcw_pkg::KIND_WRITE, 8'h55, 8'hAA, 0, 0);
		add_row(tcw_pkg::KIND_WRITE, 8'hAA, 8'h55, 0, 0);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1, 0);
		add_row(tcw_pkg::KIND_WRITE, tcw_pkg::NEWLINE_CODE, 8'h00, 0, 0);
		add_row(tcw_pkg::KIND_READ, 8'h00, 8'h00, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_item(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].want);
		drain_reports();

		// Random part: mostly text runs and newlines so that the cursor reaches
		// the bottom row, wraps on the last cell and scrolls; reads look mainly
		// at cells just behind the cursor.
		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain_reports();
				paused = 1'b1;
			end
			seg = $urandom_range(0, 99);
			if (seg < 55) begin
				n = $urandom_range(1, 100);
				for (int i = 0; i < n; i++) begin
					send_item(random_item(tcw_pkg::KIND_WRITE));
					sent++;
				end
				if ($urandom_range(0, 1) != 0) begin
					it      = random_item(tcw_pkg::KIND_WRITE);
					it.code = tcw_pkg::NEWLINE_CODE;
					send_item(it);
					sent++;
				end
			end else if (seg < 75) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					it   = random_item(tcw_pkg::KIND_READ);
					pick = $urandom_range(0, 19);
					pos  = cur_row * COLS + cur_col;
					if (pick < 14) begin
						back     = $urandom_range(0, (pos < 240) ? pos : 240);
						it.index = 11'(pos - back);
					end else if (pick < 19) begin
						it.index = 11'($urandom_range(0, CELLS - 1));
					end else begin
						it.index = 11'($urandom_range(CELLS, 2047));
					end
					send_item(it);
					sent++;
				end
			end else if (seg < 78) begin
				send_item(random_item(tcw_pkg::KIND_CLEAR));
				sent++;
			end else if (seg < 82) begin
				send_item(random_item(KIND_UNUSED));
			end else begin
				n = $urandom_range(1, 30);
				for (int i = 0; i < n; i++) begin
					it      = random_item(tcw_pkg::KIND_WRITE);
					it.code = tcw_pkg::NEWLINE_CODE;
					send_item(it);
					sent++;
				end
			end
		end

		drain_reports();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
